// ----- hw/rtl/cbm_pkg.sv -----
package cbm_pkg;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_BLOCK = 64;
    localparam int HEIGHT_LIMIT  = 4096;

    localparam int PIX_W      = 8;
    localparam int MEAN_W     = 8;
    localparam int IDX_W      = 12;
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int BS_CFG_W   = 7;
    localparam int DIM_CFG_W  = 13;
    localparam int FIFO_DEPTH = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [BS_CFG_W-1:0]  RST_BLOCK_SIZE   = 7'd8;
    localparam logic [DIM_CFG_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [DIM_CFG_W-1:0] RST_IMAGE_HEIGHT = 13'd480;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             done;
    } t_tag;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        t_tag              tag;
    } t_result;

endpackage

// ----- hw/rtl/cbm_if.sv -----
interface cbm_pix_if;
    logic                      valid;
    logic                      ready;
    logic [cbm_pkg::PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface cbm_res_if;
    logic                       valid;
    logic                       ready;
    logic [cbm_pkg::MEAN_W-1:0] block_mean;
    logic [cbm_pkg::IDX_W-1:0]  block_row;
    logic [cbm_pkg::IDX_W-1:0]  block_col;
    logic                       frame_done;

    modport source (output valid, output block_mean, output block_row, output block_col,
                    output frame_done, input ready);
    modport sink   (input valid, input block_mean, input block_row, input block_col,
                    input frame_done, output ready);
endinterface

interface cbm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cbm_pkg::CFG_IDX_W-1:0]  index;
    logic [cbm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/cbm_sum_ram.sv -----
module cbm_sum_ram #(
    parameter int DEPTH  = cbm_pkg::DEF_MAX_WIDTH,
    parameter int ADDR_W = $clog2(cbm_pkg::DEF_MAX_WIDTH),
    parameter int DATA_W = 20
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/cbm_div_pipe.sv -----
module cbm_div_pipe #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 14
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [NUM_W-1:0]           i_num,
    input  logic [DEN_W-1:0]           i_den,
    input  cbm_pkg::t_tag              i_tag,
    output logic                       o_valid,
    output logic [cbm_pkg::MEAN_W-1:0] o_quot,
    output cbm_pkg::t_tag              o_tag
);

    localparam int QW = cbm_pkg::MEAN_W;
    localparam int WW = NUM_W + QW;

    logic [NUM_W-1:0]    r_rem [QW];
    logic [QW-1:0]       r_q   [QW];
    logic [DEN_W-1:0]    r_den [QW];
    cbm_pkg::t_tag       r_tag [QW];
    logic [QW-1:0]       r_vld;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int SH = QW - 1 - k;
        logic [NUM_W-1:0] rem_in;
        logic [QW-1:0]    q_in;
        logic [DEN_W-1:0] den_in;
        cbm_pkg::t_tag    tag_in;
        logic             vld_in;
        logic [WW-1:0]    trial;
        logic [WW-1:0]    diff;
        logic             take;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign q_in   = '0;
            assign den_in = i_den;
            assign tag_in = i_tag;
            assign vld_in = i_valid;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign q_in   = r_q[k-1];
            assign den_in = r_den[k-1];
            assign tag_in = r_tag[k-1];
            assign vld_in = r_vld[k-1];
        end

        assign trial = WW'(den_in) << SH;
        assign take  = WW'(rem_in) >= trial;
        assign diff  = WW'(rem_in) - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= take ? diff[NUM_W-1:0] : rem_in;
            r_q[k]   <= take ? (q_in | (QW'(1) << SH)) : q_in;
            r_den[k] <= den_in;
            r_tag[k] <= tag_in;
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quot  = r_q[QW-1];
    assign o_tag   = r_tag[QW-1];

endmodule

// ----- hw/rtl/cbm_out_fifo.sv -----
module cbm_out_fifo #(
    parameter int DEPTH = cbm_pkg::FIFO_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  cbm_pkg::t_result           i_data,
    input  logic                       i_pop,
    output cbm_pkg::t_result           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cbm_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_count < CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("result queue underflow");

endmodule

// ----- hw/rtl/image_block_mean_core.sv -----
// a block's result passes from its last pixel through the memory read at the taking edge,
// the accumulate into the first of 8 divider stages, and the result queue
// throughput: one pixel per cycle; the input holds off only while pixels in flight
// plus queued results fill the 16-entry result queue
// reset: synchronous active low; registers return to 8, 640, 480 and the frame
// restarts at the top-left pixel; the sum memory is not cleared, a block's first pixel overwrites it
module image_block_mean_core #(
    parameter int MAX_WIDTH = cbm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BLOCK = cbm_pkg::DEF_MAX_BLOCK
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbm_pix_if.sink   i_pix,
    cbm_res_if.source o_res,
    cbm_cfg_if.sink   i_cfg
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int BS_W   = $clog2(MAX_BLOCK + 1);
    localparam int CIB_W  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int AREA_W = 2 * BS_W;
    localparam int SUM_W  = cbm_pkg::PIX_W + 2 * $clog2(MAX_BLOCK);
    localparam int ROW_W  = cbm_pkg::ROW_W;
    localparam int FD     = cbm_pkg::FIFO_DEPTH;
    localparam int CNT_W  = $clog2(FD + 1);

    logic [cbm_pkg::BS_CFG_W-1:0]  r_block_size;
    logic [cbm_pkg::DIM_CFG_W-1:0] r_image_width;
    logic [cbm_pkg::DIM_CFG_W-1:0] r_image_height;

    logic [COL_W-1:0] r_col, n_col;
    logic [CIB_W-1:0] r_cib, n_cib;
    logic [COL_W-1:0] r_bstart_col, n_bstart_col;
    logic [COL_W-1:0] r_bc, n_bc;
    logic [ROW_W-1:0] r_row, n_row;
    logic [CIB_W-1:0] r_rib, n_rib;
    logic [ROW_W-1:0] r_bstart_row, n_bstart_row;
    logic [ROW_W-1:0] r_br, n_br;

    logic [15:0]       bs16, w16, h16;
    logic [15:0]       eff_bs16, eff_w16, eff_h16;
    logic [BS_W-1:0]   eff_bs;
    logic [AREA_W-1:0] area;
    logic              col_fits, row_fits, col_last, row_last;
    logic              col_wrap, row_wrap, cib_wrap, rib_wrap;
    logic              in_acc, cfg_acc, in_blk, first_px, emit;
    logic [31:0]       bc32, br32;
    cbm_pkg::t_tag     tag_now;

    logic                        r_a_valid;
    logic                        r_a_inblk;
    logic                        r_a_emit;
    logic                        r_a_first;
    logic [COL_W-1:0]            r_a_addr;
    logic [cbm_pkg::PIX_W-1:0]   r_a_pix;
    logic [AREA_W-1:0]           r_a_area;
    cbm_pkg::t_tag               r_a_tag;
    logic                        r_fwd_hit;
    logic [SUM_W-1:0]            r_fwd_sum;
    logic [SUM_W-1:0]            rd_data;
    logic [SUM_W-1:0]            base;
    logic [SUM_W-1:0]            a_sum;
    logic                        a_we;
    logic                        n_fwd_hit;

    logic                        div_valid;
    logic [cbm_pkg::MEAN_W-1:0]  div_quot;
    cbm_pkg::t_tag               div_tag;
    cbm_pkg::t_result            push_data;
    cbm_pkg::t_result            head;
    logic [CNT_W-1:0]            fifo_count;
    logic                        pop;

    logic [CNT_W-1:0]            r_pend, n_pend;
    logic [CNT_W:0]              occupied;
    logic                        drop;

    assign bs16 = 16'(r_block_size);
    assign w16  = 16'(r_image_width);
    assign h16  = 16'(r_image_height);

    assign eff_bs16 = (bs16 == 16'd0) ? 16'd1 :
                      (bs16 > 16'(MAX_BLOCK)) ? 16'(MAX_BLOCK) : bs16;
    assign eff_w16  = (w16 == 16'd0) ? 16'd1 :
                      (w16 > 16'(MAX_WIDTH)) ? 16'(MAX_WIDTH) : w16;
    assign eff_h16  = (h16 == 16'd0) ? 16'd1 :
                      (h16 > 16'(cbm_pkg::HEIGHT_LIMIT)) ? 16'(cbm_pkg::HEIGHT_LIMIT) : h16;
    assign eff_bs   = eff_bs16[BS_W-1:0];
    assign area     = AREA_W'(eff_bs) * AREA_W'(eff_bs);

    // block fits when its far edge stays inside the image
    assign col_fits = 16'(r_bstart_col) + eff_bs16 <= eff_w16;
    assign row_fits = 16'(r_bstart_row) + eff_bs16 <= eff_h16;
    assign col_last = 16'(r_bstart_col) + (eff_bs16 << 1) > eff_w16;
    assign row_last = 16'(r_bstart_row) + (eff_bs16 << 1) > eff_h16;

    assign col_wrap = 16'(r_col) == eff_w16 - 16'd1;
    assign row_wrap = 16'(r_row) == eff_h16 - 16'd1;
    assign cib_wrap = 16'(r_cib) == eff_bs16 - 16'd1;
    assign rib_wrap = 16'(r_rib) == eff_bs16 - 16'd1;

    assign occupied    = (CNT_W + 1)'(r_pend) + (CNT_W + 1)'(fifo_count);
    assign i_pix.ready = occupied < (CNT_W + 1)'(FD);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_pix.valid && i_pix.ready;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;

    assign in_blk   = col_fits && row_fits;
    assign first_px = (r_cib == '0) && (r_rib == '0);
    assign emit     = in_blk && cib_wrap && rib_wrap;

    assign bc32         = 32'(r_bc);
    assign br32         = 32'(r_br);
    assign tag_now.row  = cbm_pkg::IDX_W'(br32);
    assign tag_now.col  = cbm_pkg::IDX_W'(bc32);
    assign tag_now.done = row_last && col_last;

    always_comb begin
        n_col        = r_col;
        n_cib        = r_cib;
        n_bstart_col = r_bstart_col;
        n_bc         = r_bc;
        n_row        = r_row;
        n_rib        = r_rib;
        n_bstart_row = r_bstart_row;
        n_br         = r_br;
        if (cfg_acc && i_cfg.index <= cbm_pkg::REG_IMAGE_HEIGHT) begin
            n_col        = '0;
            n_cib        = '0;
            n_bstart_col = '0;
            n_bc         = '0;
            n_row        = '0;
            n_rib        = '0;
            n_bstart_row = '0;
            n_br         = '0;
        end else if (in_acc) begin
            if (col_wrap) begin
                n_col        = '0;
                n_cib        = '0;
                n_bstart_col = '0;
                n_bc         = '0;
                if (row_wrap) begin
                    n_row        = '0;
                    n_rib        = '0;
                    n_bstart_row = '0;
                    n_br         = '0;
                end else begin
                    n_row = r_row + ROW_W'(1);
                    if (rib_wrap) begin
                        n_rib        = '0;
                        n_bstart_row = r_bstart_row + ROW_W'(eff_bs16);
                        n_br         = r_br + ROW_W'(1);
                    end else begin
                        n_rib = r_rib + CIB_W'(1);
                    end
                end
            end else begin
                n_col = r_col + COL_W'(1);
                if (cib_wrap) begin
                    n_cib        = '0;
                    n_bstart_col = r_bstart_col + COL_W'(eff_bs16);
                    n_bc         = r_bc + COL_W'(1);
                end else begin
                    n_cib = r_cib + CIB_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size   <= cbm_pkg::RST_BLOCK_SIZE;
            r_image_width  <= cbm_pkg::RST_IMAGE_WIDTH;
            r_image_height <= cbm_pkg::RST_IMAGE_HEIGHT;
        end else if (cfg_acc) begin
            unique case (i_cfg.index)
                cbm_pkg::REG_BLOCK_SIZE:   r_block_size   <= i_cfg.data[cbm_pkg::BS_CFG_W-1:0];
                cbm_pkg::REG_IMAGE_WIDTH:  r_image_width  <= i_cfg.data;
                cbm_pkg::REG_IMAGE_HEIGHT: r_image_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_cib        <= '0;
            r_bstart_col <= '0;
            r_bc         <= '0;
            r_row        <= '0;
            r_rib        <= '0;
            r_bstart_row <= '0;
            r_br         <= '0;
        end else begin
            r_col        <= n_col;
            r_cib        <= n_cib;
            r_bstart_col <= n_bstart_col;
            r_bc         <= n_bc;
            r_row        <= n_row;
            r_rib        <= n_rib;
            r_bstart_row <= n_bstart_row;
            r_br         <= n_br;
        end
    end

    // accumulate stage: read data arrives in the cycle after the item is taken
    cbm_sum_ram #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W),
        .DATA_W (SUM_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (r_a_addr),
        .i_wdata (a_sum),
        .i_raddr (r_bc),
        .o_rdata (rd_data)
    );

    assign a_we      = r_a_valid && r_a_inblk;
    assign base      = r_fwd_hit ? r_fwd_sum : rd_data;
    assign a_sum     = r_a_first ? SUM_W'(r_a_pix) : base + SUM_W'(r_a_pix);
    // read of the same column in the cycle of its write returns the old sum
    assign n_fwd_hit = a_we && in_acc && in_blk && (r_a_addr == r_bc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_a_valid <= in_acc;
            r_fwd_hit <= n_fwd_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_inblk <= in_blk;
        r_a_emit  <= emit;
        r_a_first <= first_px;
        r_a_addr  <= r_bc;
        r_a_pix   <= i_pix.pixel_value;
        r_a_area  <= area;
        r_a_tag   <= tag_now;
        r_fwd_sum <= a_sum;
    end

    cbm_div_pipe #(
        .NUM_W (SUM_W),
        .DEN_W (AREA_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_valid && r_a_emit),
        .i_num   (a_sum),
        .i_den   (r_a_area),
        .i_tag   (r_a_tag),
        .o_valid (div_valid),
        .o_quot  (div_quot),
        .o_tag   (div_tag)
    );

    assign push_data.mean = div_quot;
    assign push_data.tag  = div_tag;
    assign pop            = o_res.valid && o_res.ready;

    cbm_out_fifo #(
        .DEPTH (FD)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (div_valid),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (head),
        .o_count (fifo_count)
    );

    assign o_res.valid      = fifo_count != '0;
    assign o_res.block_mean = head.mean;
    assign o_res.block_row  = head.tag.row;
    assign o_res.block_col  = head.tag.col;
    assign o_res.frame_done = head.tag.done;

    // items taken but not yet dropped or queued
    assign drop = r_a_valid && !r_a_emit;

    always_comb begin
        n_pend = r_pend;
        if (in_acc) begin
            n_pend = n_pend + CNT_W'(1);
        end
        if (drop) begin
            n_pend = n_pend - CNT_W'(1);
        end
        if (div_valid) begin
            n_pend = n_pend - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occupied <= (CNT_W + 1)'(FD))
        else $error("items in flight exceed result queue space");

    a_fwd_needs_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> r_a_valid && r_a_inblk)
        else $error("forwarded sum without matching accumulate");

    a_emit_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_a_emit |-> r_a_inblk)
        else $error("result from a pixel outside any full block");

    a_pos_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(cfg_acc) |->
            16'(r_cib) < eff_bs16 && 16'(r_col) < eff_w16 && 16'(r_row) < eff_h16)
        else $error("position counter out of range");

endmodule

// ----- verif/image_block_mean_core_tb.sv -----
module image_block_mean_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 450;
    localparam int MAX_PHASE    = 300;

    typedef enum int {RX_OPEN, RX_HALF, RX_MOSTLY, RX_SPARSE} t_rx_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  pix_valid   = 1'b0;
    logic [PIX_W-1:0]      pix_value   = '0;
    logic                  res_ready   = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  pressure_on = 1'b0;

    logic [BS_CFG_W-1:0]  blk_size_reg;
    logic [DIM_CFG_W-1:0] width_reg;
    logic [DIM_CFG_W-1:0] height_reg;
    logic [19:0]          band_sums [DEF_MAX_WIDTH];
    logic [IDX_W-1:0]     next_col;
    logic [ROW_W-1:0]     next_row;
    logic [5:0]           row_in_blk;
    logic [5:0]           col_in_blk;

    t_result          pending_means [$];
    logic [PIX_W-1:0] pixel_backlog [$];

    int       fail_count   = 0;
    int       cycle_count  = 0;
    int       random_items = 0;
    int       burst_left;
    int       gap_left;
    int       hold_left;
    bit       hold_taken;
    logic [31:0] stall_bits;
    int       stall_left;
    t_rx_mode stall_mode;
    bit       rx_take;

    cbm_pix_if pix_bus ();
    cbm_res_if res_bus ();
    cbm_cfg_if cfg_bus ();

    assign pix_bus.valid       = pix_valid;
    assign pix_bus.pixel_value = pix_value;
    assign res_bus.ready       = res_ready;
    assign cfg_bus.valid       = cfg_valid;
    assign cfg_bus.index       = cfg_index;
    assign cfg_bus.data        = cfg_data;

    image_block_mean_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void restart_position();
        next_col   = '0;
        next_row   = '0;
        row_in_blk = '0;
        col_in_blk = '0;
    endfunction

    function automatic void predict_block_mean(input logic [PIX_W-1:0] pixel);
        int      bs;
        int      w;
        int      h;
        int      bc;
        int      br;
        t_result r;
        bs = (blk_size_reg == 0) ? 1 :
             (blk_size_reg > DEF_MAX_BLOCK) ? DEF_MAX_BLOCK : int'(blk_size_reg);
        w  = (width_reg == 0) ? 1 :
             (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
        h  = (height_reg == 0) ? 1 :
             (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(height_reg);
        bc = int'(next_col) / bs;
        br = int'(next_row) / bs;
        if (bc < w / bs && br < h / bs) begin
            if (row_in_blk == 0 && col_in_blk == 0) begin
                band_sums[bc] = 20'(pixel);
            end else begin
                band_sums[bc] = band_sums[bc] + 20'(pixel);
            end
            if (int'(row_in_blk) == bs - 1 && int'(col_in_blk) == bs - 1) begin
                r.mean     = MEAN_W'(int'(band_sums[bc]) / (bs * bs));
                r.tag.row  = IDX_W'(br);
                r.tag.col  = IDX_W'(bc);
                r.tag.done = (br == h / bs - 1) && (bc == w / bs - 1);
                pending_means.push_back(r);
            end
        end
        col_in_blk = (int'(col_in_blk) + 1 >= bs) ? 6'd0 : col_in_blk + 6'd1;
        if (int'(next_col) + 1 >= w) begin
            next_col   = '0;
            col_in_blk = '0;
            if (int'(next_row) + 1 >= h) begin
                next_row   = '0;
                row_in_blk = '0;
            end else begin
                next_row   = next_row + 1'b1;
                row_in_blk = (int'(row_in_blk) + 1 >= bs) ? 6'd0 : row_in_blk + 6'd1;
            end
        end else begin
            next_col = next_col + 1'b1;
        end
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // pixel sender: bursts of random length, random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_valid  <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (pix_valid && pix_bus.ready) begin
                predict_block_mean(pix_value);
            end
            if (!pix_valid || pix_bus.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    pix_valid <= 1'b0;
                end else if (pixel_backlog.size() != 0) begin
                    pix_valid <= 1'b1;
                    pix_value <= pixel_backlog.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    pix_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the result queue fills and the input stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else if (pressure_on && !hold_taken) begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ready  <= 1'b0;
            stall_left = 0;
        end else begin
            if (stall_left == 0) begin
                stall_bits = $urandom;
                stall_mode = t_rx_mode'($urandom_range(0, 3));
                stall_left = 32;
            end
            stall_left--;
            case (stall_mode)
                RX_OPEN:   rx_take = 1'b1;
                RX_HALF:   rx_take = stall_bits[stall_left];
                RX_MOSTLY: rx_take = stall_bits[stall_left] | stall_bits[31 - stall_left];
                default:   rx_take = stall_bits[stall_left] & stall_bits[31 - stall_left];
            endcase
            res_ready <= rx_take && (hold_left == 0);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_bus.valid && res_ready) begin
            if (pending_means.size() == 0) begin
                note_failure($sformatf("unexpected result: mean %0d row %0d col %0d done %0b",
                    res_bus.block_mean, res_bus.block_row, res_bus.block_col,
                    res_bus.frame_done));
            end else begin
                want = pending_means.pop_front();
                if (want.mean !== res_bus.block_mean || want.tag.row !== res_bus.block_row ||
                    want.tag.col !== res_bus.block_col ||
                    want.tag.done !== res_bus.frame_done) begin
                    note_failure($sformatf(
                        "mismatch: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                        want.mean, want.tag.row, want.tag.col, want.tag.done,
                        res_bus.block_mean, res_bus.block_row, res_bus.block_col,
                        res_bus.frame_done));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("image_block_mean_core regression: fail");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pixel_backlog.size() != 0 || pix_valid || pending_means.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BLOCK_SIZE:   blk_size_reg = value[BS_CFG_W-1:0];
            REG_IMAGE_WIDTH:  width_reg    = value;
            REG_IMAGE_HEIGHT: height_reg   = value;
            default: ;
        endcase
        if (idx != REG_UNUSED) begin
            restart_position();
        end
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] bs_val,
                             input logic [CFG_DATA_W-1:0] w_val,
                             input logic [CFG_DATA_W-1:0] h_val);
        wait_idle();
        write_register(REG_BLOCK_SIZE, bs_val);
        write_register(REG_IMAGE_WIDTH, w_val);
        write_register(REG_IMAGE_HEIGHT, h_val);
    endtask

    task automatic queue_random(input int count);
        repeat (count) pixel_backlog.push_back(random_pixel());
        random_items += count;
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] bs_val;
        logic [CFG_DATA_W-1:0] w_val;
        logic [CFG_DATA_W-1:0] h_val;
        int                    pick;
        int                    frame;
        int                    count;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        blk_size_reg = RST_BLOCK_SIZE;
        width_reg    = RST_IMAGE_WIDTH;
        height_reg   = RST_IMAGE_HEIGHT;
        restart_position();

        // reset geometry, no full block yet
        pixel_backlog.push_back(8'h5A);

        // zero block size acts as one, every pixel is a block, frame wraps
        configure(13'd0, 13'd2, 13'd2);
        pixel_backlog.push_back(8'h00);
        pixel_backlog.push_back(8'hFF);
        pixel_backlog.push_back(8'h55);
        pixel_backlog.push_back(8'hAA);
        pixel_backlog.push_back(8'h01);

        // oversized block, zero width, oversized height: nothing emitted
        configure(13'h1FFF, 13'd0, 13'h1FFF);
        pixel_backlog.push_back(8'hFF);
        pixel_backlog.push_back(8'h00);

        // upper block-size bits ignored, right and bottom remainder dropped
        configure({6'h3F, 7'd2}, 13'd3, 13'd3);
        pixel_backlog.push_back(8'hFF);
        pixel_backlog.push_back(8'hFF);
        pixel_backlog.push_back(8'h80);
        pixel_backlog.push_back(8'hFF);
        pixel_backlog.push_back(8'hFE);
        pixel_backlog.push_back(8'h01);
        pixel_backlog.push_back(8'h7F);
        pixel_backlog.push_back(8'h7F);
        pixel_backlog.push_back(8'h7F);
        pixel_backlog.push_back(8'h00);
        pixel_backlog.push_back(8'hFF);

        // write to an unused index mid-frame must not restart the frame
        wait_idle();
        write_register(REG_UNUSED, 13'h1FFF);
        pixel_backlog.push_back(8'h80);
        pixel_backlog.push_back(8'h10);
        pixel_backlog.push_back(8'h20);
        pixel_backlog.push_back(8'h30);
        pixel_backlog.push_back(8'h40);
        pixel_backlog.push_back(8'h50);
        pixel_backlog.push_back(8'h60);

        // width beyond limit saturates
        configure(13'd1, 13'h1FFF, 13'd1);
        queue_random(48);

        // one result per pixel while the receiver holds off
        configure(13'd1, 13'd16, 13'd16);
        pressure_on <= 1'b1;
        queue_random(256);
        wait_idle();
        pressure_on <= 1'b0;

        // large block, sum near full scale
        configure(13'd32, 13'd32, 13'd32);
        repeat (1024) begin
            pixel_backlog.push_back(($urandom_range(0, 3) != 0) ? 8'hFF : random_pixel());
        end

        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                bs_val = CFG_DATA_W'($urandom_range(1, 4));
            end else if (pick < 9) begin
                bs_val = CFG_DATA_W'($urandom_range(5, 8));
            end else begin
                bs_val = ($urandom_range(0, 1) != 0) ? 13'd0 : CFG_DATA_W'($urandom_range(64, 127));
            end
            w_val = CFG_DATA_W'($urandom_range(0, 20));
            h_val = CFG_DATA_W'($urandom_range(0, 12));
            case ($urandom_range(0, 5))
                0: begin
                    wait_idle();
                    write_register(REG_BLOCK_SIZE, bs_val);
                end
                1: begin
                    wait_idle();
                    write_register(REG_IMAGE_HEIGHT, h_val);
                end
                default: begin
                    configure(bs_val, w_val, h_val);
                end
            endcase
            frame = ((width_reg == 0) ? 1 : int'(width_reg)) *
                    ((height_reg == 0) ? 1 : int'(height_reg));
            count = $urandom_range(frame / 2 + 1, 2 * frame);
            if (count > MAX_PHASE) begin
                count = MAX_PHASE;
            end
            queue_random(count);
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("image_block_mean_core regression: pass");
        end else begin
            $display("image_block_mean_core regression: fail");
        end
        $finish;
    end

endmodule
